/* hw/rtl/cwcc_pkg.sv */
// Shared types, widths and palette table of the center window color classifier.
// Used by cwcc_classify and center_window_color_classifier; depends on nothing.
package cwcc_pkg;

  localparam int WINDOW_SIZE = 120;
  localparam int WIN_LOG     = $clog2(WINDOW_SIZE);
  localparam int SUM_W       = 8 + 2 * WIN_LOG;
  localparam int CNT_W       = 2 * WIN_LOG + 1;
  localparam int MAG_W       = CNT_W + 8;
  localparam int DIFF_W      = MAG_W + 1;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int POS_W       = 12;
  localparam int SYM_W       = 3;

  localparam logic [POS_W:0] WIN_LEN  = (POS_W + 1)'(WINDOW_SIZE);
  localparam logic [POS_W:0] WIN_HALF = (POS_W + 1)'(WINDOW_SIZE / 2);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_OCTAL_MODE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } chan_t;

  typedef struct packed {
    logic start;
    logic ack;
  } cwcc_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SYM_W-1:0] symbol;
  } cwcc_stat_t;

  // palette channel is either 0 or 255; returns 1 for 255
  function automatic logic pal_chan(input logic octal, input logic [SYM_W-1:0] idx,
                                    input chan_t ch);
    logic [2:0] bgr;
    if (!octal) begin
      bgr = (idx == '0) ? 3'b111 : 3'b000;
    end else begin
      case (idx)
        3'd0:    bgr = 3'b000;
        3'd1:    bgr = 3'b111;
        3'd2:    bgr = 3'b001;
        3'd3:    bgr = 3'b100;
        3'd4:    bgr = 3'b010;
        3'd5:    bgr = 3'b101;
        3'd6:    bgr = 3'b011;
        default: bgr = 3'b110;
      endcase
    end
    case (ch)
      CH_BLUE:  return bgr[2];
      CH_GREEN: return bgr[1];
      default:  return bgr[0];
    endcase
  endfunction

endpackage

/* hw/rtl/cwcc_classify.sv */
// Sequenced nearest-palette search over the window sums with one shared squarer.
// Depends on cwcc_pkg.
module cwcc_classify import cwcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cwcc_ctl_t        ctl,
  input  logic [SUM_W-1:0] blue_sum,
  input  logic [SUM_W-1:0] green_sum,
  input  logic [SUM_W-1:0] red_sum,
  input  logic [CNT_W-1:0] window_pixels,
  input  logic             octal_mode,
  output cwcc_stat_t       stat
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIFF = 6'b000010,
    S_SQR  = 6'b000100,
    S_ACC  = 6'b001000,
    S_CMP  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [SUM_W-1:0]  sum_r [3];
  logic [CNT_W-1:0]  n_r;
  logic              mode_r;
  logic [SYM_W-1:0]  idx_r, idx_nxt;
  chan_t             ch_r, ch_nxt;
  logic [MAG_W-1:0]  mag_r;
  logic [SQ_W-1:0]   sq_r;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [DIST_W-1:0] best_r;
  logic [SYM_W-1:0]  best_idx_r;

  logic [MAG_W-1:0]        np;
  logic signed [DIFF_W-1:0] diff;
  logic [SYM_W-1:0]        last_idx;

  always_comb begin
    np = pal_chan(mode_r, idx_r, ch_r) ? ({n_r, 8'd0} - MAG_W'(n_r)) : '0;
    diff = $signed({1'b0, MAG_W'(sum_r[ch_r])}) - $signed({1'b0, np});
    last_idx = mode_r ? SYM_W'(7) : SYM_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ch_nxt    = ch_r;
    dist_nxt  = dist_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          state_nxt = S_DIFF;
          idx_nxt   = '0;
          ch_nxt    = CH_BLUE;
          dist_nxt  = '0;
        end
      end
      S_DIFF: state_nxt = S_SQR;
      S_SQR:  state_nxt = S_ACC;
      S_ACC: begin
        dist_nxt = dist_r + DIST_W'(sq_r);
        if (ch_r == CH_RED) begin
          state_nxt = S_CMP;
        end else begin
          ch_nxt    = chan_t'(ch_r + 2'd1);
          state_nxt = S_DIFF;
        end
      end
      S_CMP: begin
        if (idx_r == last_idx) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + SYM_W'(1);
          ch_nxt    = CH_BLUE;
          dist_nxt  = '0;
          state_nxt = S_DIFF;
        end
      end
      S_DONE: begin
        if (ctl.ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    ch_r   <= ch_nxt;
    dist_r <= dist_nxt;
    if (state_r == S_IDLE && ctl.start) begin
      sum_r[0] <= blue_sum;
      sum_r[1] <= green_sum;
      sum_r[2] <= red_sum;
      n_r      <= window_pixels;
      mode_r   <= octal_mode;
    end
    if (state_r == S_DIFF) begin
      mag_r <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end
    if (state_r == S_SQR) begin
      sq_r <= mag_r * mag_r;
    end
    if (state_r == S_CMP && (idx_r == '0 || dist_r < best_r)) begin
      best_r     <= dist_r;
      best_idx_r <= idx_r;
    end
  end

  assign stat.busy   = (state_r != S_IDLE);
  assign stat.done   = (state_r == S_DONE);
  assign stat.symbol = best_idx_r;

endmodule

/* hw/rtl/center_window_color_classifier.sv */
// Top level: pixel position counters, centered window sums, config registers
// and result register. Depends on cwcc_pkg and cwcc_classify.

// Pixels are accepted one per clock while the classifier is idle. The last pixel
// of a frame starts the palette search in cwcc_classify, which runs one shared
// squarer over every palette entry and channel: difference, square and accumulate
// per channel, then one compare per entry. in_ready is low during the search and
// until the symbol word moves into an output register, where it sits; pixels of
// the next frame are accepted while it waits to be taken.
module center_window_color_classifier import cwcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [POS_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_pixel_blue,
  input  logic [7:0]       in_pixel_green,
  input  logic [7:0]       in_pixel_red,
  input  logic             in_frame_start,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_symbol
);

  logic [POS_W-1:0] frame_width_r, frame_height_r;
  logic             octal_mode_r;
  logic [POS_W-1:0] column_count_r, row_count_r;
  logic [SUM_W-1:0] blue_sum_r, green_sum_r, red_sum_r;
  logic [CNT_W-1:0] window_pixels_r;
  logic             out_valid_r;
  logic [SYM_W-1:0] out_symbol_r;

  logic [POS_W-1:0] w, h, col_b, row_b;
  logic [POS_W:0]   x0, x_end, y0, y_end, half, rest;
  logic [SUM_W-1:0] blue_nxt, green_nxt, red_nxt, blue_b, green_b, red_b;
  logic [CNT_W-1:0] cnt_nxt, cnt_b;
  logic             in_win, line_end, frame_end, accept;
  cwcc_ctl_t        ctl;
  cwcc_stat_t       stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    w = (frame_width_r == '0) ? POS_W'(1) : frame_width_r;
    h = (frame_height_r == '0) ? POS_W'(1) : frame_height_r;

    half  = {1'b0, w} >> 1;
    x0    = (half > WIN_HALF) ? half - WIN_HALF : '0;
    rest  = {1'b0, w} - x0;
    x_end = x0 + ((rest < WIN_LEN) ? rest : WIN_LEN);

    half  = {1'b0, h} >> 1;
    y0    = (half > WIN_HALF) ? half - WIN_HALF : '0;
    rest  = {1'b0, h} - y0;
    y_end = y0 + ((rest < WIN_LEN) ? rest : WIN_LEN);

    col_b   = in_frame_start ? '0 : column_count_r;
    row_b   = in_frame_start ? '0 : row_count_r;
    blue_b  = in_frame_start ? '0 : blue_sum_r;
    green_b = in_frame_start ? '0 : green_sum_r;
    red_b   = in_frame_start ? '0 : red_sum_r;
    cnt_b   = in_frame_start ? '0 : window_pixels_r;

    in_win = ({1'b0, col_b} >= x0) && ({1'b0, col_b} < x_end) &&
             ({1'b0, row_b} >= y0) && ({1'b0, row_b} < y_end);

    blue_nxt  = in_win ? blue_b + SUM_W'(in_pixel_blue) : blue_b;
    green_nxt = in_win ? green_b + SUM_W'(in_pixel_green) : green_b;
    red_nxt   = in_win ? red_b + SUM_W'(in_pixel_red) : red_b;
    cnt_nxt   = in_win ? cnt_b + CNT_W'(1) : cnt_b;

    line_end  = (col_b >= w - POS_W'(1));
    frame_end = line_end && (row_b >= h - POS_W'(1));
  end

  assign in_ready  = !stat.busy;
  assign accept    = in_valid && in_ready;
  assign ctl.start = accept && frame_end;
  assign ctl.ack   = stat.done && (!out_valid_r || out_ready);

  cwcc_classify u_classify (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .blue_sum      (blue_nxt),
    .green_sum     (green_nxt),
    .red_sum       (red_nxt),
    .window_pixels (cnt_nxt),
    .octal_mode    (octal_mode_r),
    .stat          (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= POS_W'(1280);
      frame_height_r  <= POS_W'(720);
      octal_mode_r    <= 1'b0;
      column_count_r  <= '0;
      row_count_r     <= '0;
      blue_sum_r      <= '0;
      green_sum_r     <= '0;
      red_sum_r       <= '0;
      window_pixels_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          REG_OCTAL_MODE:   octal_mode_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (frame_end) begin
          column_count_r  <= '0;
          row_count_r     <= '0;
          blue_sum_r      <= '0;
          green_sum_r     <= '0;
          red_sum_r       <= '0;
          window_pixels_r <= '0;
        end else begin
          blue_sum_r      <= blue_nxt;
          green_sum_r     <= green_nxt;
          red_sum_r       <= red_nxt;
          window_pixels_r <= cnt_nxt;
          if (line_end) begin
            column_count_r <= '0;
            row_count_r    <= row_b + POS_W'(1);
          end else begin
            column_count_r <= col_b + POS_W'(1);
            row_count_r    <= row_b;
          end
        end
      end
      if (ctl.ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ack) out_symbol_r <= stat.symbol;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;

endmodule

/* tb/sv/tb_center_window_color_classifier.sv */
// Testbench for center_window_color_classifier: a directed table, then random frames,
// checked word by word against a predictor of window sums and nearest palette color.
// Depends on cwcc_pkg and the RTL of center_window_color_classifier.
`timescale 1ns / 100ps

module tb_center_window_color_classifier;
  import cwcc_pkg::*;

  localparam int RAND_ITEMS   = 1100;
  localparam int QUIET_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DIR_ROWS     = 30;
  localparam int MAX_REPORTS  = 10;

  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_PIX, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [1:0]       reg_idx;
    logic [POS_W-1:0] reg_data;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic             start;
    logic             checked;
    logic [SYM_W-1:0] symbol;
  } dir_row_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [POS_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_pixel_blue = '0;
  logic [7:0]       in_pixel_green = '0;
  logic [7:0]       in_pixel_red = '0;
  logic             in_frame_start = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [SYM_W-1:0] out_symbol;

  center_window_color_classifier u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_blue (in_pixel_blue),
    .in_pixel_green(in_pixel_green),
    .in_pixel_red  (in_pixel_red),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_symbol    (out_symbol)
  );

  // predictor state
  logic [POS_W-1:0] reg_width  = 12'd1280;
  logic [POS_W-1:0] reg_height = 12'd720;
  logic             reg_octal  = 1'b0;
  int unsigned      pos_col, pos_row;
  int unsigned      acc_blue, acc_green, acc_red, acc_count;

  logic [SYM_W-1:0] expected_symbols [$];
  logic [SYM_W-1:0] want_symbol;
  int               fail_count = 0;
  int               cycle_count = 0;
  logic             quiet = 1'b0;
  logic             phase_calm = 1'b0;
  int               stall_left = 0;
  int               calm_left = 0;
  int               out_roll;
  dir_row_t         dir_rows [0:DIR_ROWS-1];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_frame();
    pos_col   = 0;
    pos_row   = 0;
    acc_blue  = 0;
    acc_green = 0;
    acc_red   = 0;
    acc_count = 0;
  endfunction

  function automatic void window_span(input int unsigned extent, output int unsigned lo,
                                      output int unsigned len);
    int unsigned half, rest;
    half = extent / 2;
    lo   = (half > WINDOW_SIZE / 2) ? half - WINDOW_SIZE / 2 : 0;
    rest = extent - lo;
    len  = (rest < WINDOW_SIZE) ? rest : WINDOW_SIZE;
  endfunction

  // packed as {blue, green, red}
  function automatic logic [23:0] palette_bgr(input logic octal, input int idx);
    if (!octal) begin
      return (idx == 0) ? 24'hFFFFFF : 24'h000000;
    end
    case (idx)
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h0000FF;
      3:       return 24'hFF0000;
      4:       return 24'h00FF00;
      5:       return 24'hFF00FF;
      6:       return 24'h00FFFF;
      default: return 24'hFFFF00;
    endcase
  endfunction

  function automatic longint chan_sq(input int unsigned acc, input int unsigned n,
                                     input logic [7:0] p);
    longint diff;
    diff = longint'(acc) - longint'(n) * longint'(p);
    return diff * diff;
  endfunction

  function automatic logic [SYM_W-1:0] nearest_color();
    int               n_col, i;
    longint           best_d, d;
    logic [SYM_W-1:0] best;
    logic [23:0]      p;
    n_col  = reg_octal ? 8 : 2;
    best   = '0;
    best_d = 0;
    for (i = 0; i < n_col; i++) begin
      p = palette_bgr(reg_octal, i);
      d = chan_sq(acc_blue, acc_count, p[23:16]) + chan_sq(acc_green, acc_count, p[15:8])
        + chan_sq(acc_red, acc_count, p[7:0]);
      if (i == 0 || d < best_d) begin
        best_d = d;
        best   = SYM_W'(i);
      end
    end
    return best;
  endfunction

  function automatic logic predict_pixel(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r, input logic fs,
                                         output logic [SYM_W-1:0] sym);
    int unsigned w, h, x0, wl, y0, hl;
    logic        line_end, frame_end;
    w = (reg_width == 0) ? 1 : reg_width;
    h = (reg_height == 0) ? 1 : reg_height;
    sym = '0;
    if (fs) clear_frame();
    window_span(w, x0, wl);
    window_span(h, y0, hl);
    if (pos_col >= x0 && pos_col < x0 + wl && pos_row >= y0 && pos_row < y0 + hl) begin
      acc_blue  += b;
      acc_green += g;
      acc_red   += r;
      acc_count += 1;
    end
    line_end  = pos_col >= w - 1;
    frame_end = line_end && pos_row >= h - 1;
    if (frame_end) begin
      sym = nearest_color();
      clear_frame();
      return 1'b1;
    end
    if (line_end) begin
      pos_col = 0;
      pos_row = (pos_row + 1) & 12'hFFF;
    end else begin
      pos_col = (pos_col + 1) & 12'hFFF;
    end
    return 1'b0;
  endfunction

  function automatic dir_row_t pix_row(input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r, input logic fs);
    dir_row_t row;
    row.kind     = ROW_PIX;
    row.reg_idx  = '0;
    row.reg_data = '0;
    row.blue     = b;
    row.green    = g;
    row.red      = r;
    row.start    = fs;
    row.checked  = 1'b0;
    row.symbol   = '0;
    return row;
  endfunction

  function automatic dir_row_t chk_row(input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r, input logic fs,
                                       input logic [SYM_W-1:0] sym);
    dir_row_t row;
    row         = pix_row(b, g, r, fs);
    row.checked = 1'b1;
    row.symbol  = sym;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [POS_W-1:0] data);
    dir_row_t row;
    row          = pix_row('0, '0, '0, 1'b0);
    row.kind     = ROW_REG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic int unsigned pick_extent(input int unsigned short_max);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll <= 2) return $urandom_range(118, 124);
    return $urandom_range(1, short_max);
  endfunction

  // wait for the block to drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [POS_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  reg_width  = data;
      REG_FRAME_HEIGHT: reg_height = data;
      REG_OCTAL_MODE:   reg_octal  = data[0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic fs, input logic checked,
                            input logic [SYM_W-1:0] typed_sym);
    logic             hit;
    logic [SYM_W-1:0] sym;
    int               gap;
    if (!quiet && !phase_calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_blue  <= b;
    in_pixel_green <= g;
    in_pixel_red   <= r;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit = predict_pixel(b, g, r, fs, sym);
    if (hit) expected_symbols.push_back(checked ? typed_sym : sym);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_symbols.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected symbol word %0d", out_symbol);
      end else begin
        want_symbol = expected_symbols.pop_front();
        if (out_symbol !== want_symbol) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("symbol mismatch: expected %0d, got %0d", want_symbol, out_symbol);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_roll = $urandom_range(0, 99);
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm_left != 0) begin
      out_ready <= 1'b1;
      calm_left <= calm_left - 1;
    end else if (out_roll < 10) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else if (out_roll == 10) begin
      out_ready <= 1'b1;
      calm_left <= $urandom_range(50, 300);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int               row_i, phase, frame_len, n_items, k, mode, rand_items;
    int unsigned      w_new, h_new, w_eff, h_eff;
    logic             big, noise, fs;
    logic [2:0]       corner;
    logic [23:0]      tone;
    logic [7:0]       pb, pg, pr;

    clear_frame();

    // defaults, then registers lowered mid-frame so the counters overrun
    dir_rows[0]  = pix_row(8'd255, 8'd255, 8'd255, 1'b1);
    dir_rows[1]  = pix_row(8'd0, 8'd0, 8'd0, 1'b0);
    dir_rows[2]  = pix_row(8'd12, 8'd34, 8'd56, 1'b0);
    dir_rows[3]  = reg_row(REG_FRAME_WIDTH, 12'd3);
    dir_rows[4]  = reg_row(REG_FRAME_HEIGHT, 12'd2);
    dir_rows[5]  = pix_row(8'd0, 8'd0, 8'd0, 1'b0);
    dir_rows[6]  = pix_row(8'd255, 8'd255, 8'd255, 1'b0);
    dir_rows[7]  = pix_row(8'd255, 8'd255, 8'd255, 1'b0);
    dir_rows[8]  = chk_row(8'd255, 8'd255, 8'd255, 1'b0, 3'd0);
    // zero width acts as one: every pixel is a frame
    dir_rows[9]  = reg_row(REG_FRAME_WIDTH, 12'd0);
    dir_rows[10] = reg_row(REG_FRAME_HEIGHT, 12'd1);
    dir_rows[11] = chk_row(8'd0, 8'd0, 8'd0, 1'b1, 3'd1);
    dir_rows[12] = chk_row(8'd255, 8'd255, 8'd255, 1'b0, 3'd0);
    dir_rows[13] = pix_row(8'd128, 8'd128, 8'd128, 1'b0);
    dir_rows[14] = pix_row(8'd127, 8'd127, 8'd127, 1'b0);
    dir_rows[15] = reg_row(REG_OCTAL_MODE, 12'd1);
    dir_rows[16] = reg_row(REG_SPARE, 12'hFFF);
    dir_rows[17] = chk_row(8'd0, 8'd0, 8'd0, 1'b0, 3'd0);
    dir_rows[18] = chk_row(8'd255, 8'd255, 8'd255, 1'b0, 3'd1);
    dir_rows[19] = chk_row(8'd0, 8'd0, 8'd255, 1'b0, 3'd2);
    dir_rows[20] = chk_row(8'd255, 8'd0, 8'd0, 1'b0, 3'd3);
    dir_rows[21] = chk_row(8'd0, 8'd255, 8'd0, 1'b0, 3'd4);
    dir_rows[22] = chk_row(8'd255, 8'd0, 8'd255, 1'b0, 3'd5);
    dir_rows[23] = chk_row(8'd0, 8'd255, 8'd255, 1'b0, 3'd6);
    dir_rows[24] = chk_row(8'd255, 8'd255, 8'd0, 1'b0, 3'd7);
    // frame cut short before the window is reached
    dir_rows[25] = reg_row(REG_FRAME_WIDTH, 12'd4095);
    dir_rows[26] = pix_row(8'd1, 8'd2, 8'd3, 1'b1);
    dir_rows[27] = pix_row(8'd4, 8'd5, 8'd6, 1'b0);
    dir_rows[28] = reg_row(REG_FRAME_WIDTH, 12'd1);
    dir_rows[29] = chk_row(8'd7, 8'd8, 8'd9, 1'b0, 3'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row_i = 0; row_i < DIR_ROWS; row_i++) begin
      if (dir_rows[row_i].kind == ROW_REG) begin
        write_reg(dir_rows[row_i].reg_idx, dir_rows[row_i].reg_data);
      end else begin
        send_pixel(dir_rows[row_i].blue, dir_rows[row_i].green, dir_rows[row_i].red,
                   dir_rows[row_i].start, dir_rows[row_i].checked, dir_rows[row_i].symbol);
      end
    end

    phase      = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      phase++;
      big        = (phase == 2 || phase == 4 || phase == 6);
      noise      = !big && $urandom_range(0, 5) == 0;
      phase_calm = $urandom_range(0, 3) == 0;
      if (big) begin
        w_new = (phase == 2) ? 130 : (phase == 4) ? 1 : 122;
        h_new = (phase == 2) ? 1 : (phase == 4) ? 130 : 2;
      end else begin
        w_new = pick_extent(8);
        h_new = pick_extent(6);
        if (w_new > 8 && h_new > 8) h_new = $urandom_range(1, 2);
      end
      if (big || w_new != reg_width || $urandom_range(0, 1) == 0)
        write_reg(REG_FRAME_WIDTH, w_new[POS_W-1:0]);
      if (big || h_new != reg_height || $urandom_range(0, 1) == 0)
        write_reg(REG_FRAME_HEIGHT, h_new[POS_W-1:0]);
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_OCTAL_MODE, POS_W'($urandom_range(0, 4095)));

      w_eff     = (reg_width == 0) ? 1 : reg_width;
      h_eff     = (reg_height == 0) ? 1 : reg_height;
      frame_len = w_eff * h_eff;
      if (big) n_items = frame_len;
      else if (noise) n_items = $urandom_range(1, 30);
      else begin
        n_items = $urandom_range(1, 4) * frame_len;
        if ($urandom_range(0, 4) == 0) n_items += $urandom_range(0, frame_len - 1);
      end

      for (k = 0; k < n_items && rand_items < RAND_ITEMS; k++) begin
        if (k % frame_len == 0) begin
          mode   = (big && phase == 6) ? 3 : $urandom_range(0, 3);
          corner = 3'($urandom_range(0, 7));
          tone   = (big && phase == 6) ? 24'hFFFFFF : 24'($urandom);
          fs     = big ? (k == 0) : ($urandom_range(0, 1) == 1);
        end else begin
          fs = big ? 1'b0 : noise ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 59) == 0);
        end
        case (mode)
          0: begin
            pb = 8'($urandom_range(0, 255));
            pg = 8'($urandom_range(0, 255));
            pr = 8'($urandom_range(0, 255));
          end
          1: begin
            pb = corner[2] ? 8'(255 - $urandom_range(0, 60)) : 8'($urandom_range(0, 60));
            pg = corner[1] ? 8'(255 - $urandom_range(0, 60)) : 8'($urandom_range(0, 60));
            pr = corner[0] ? 8'(255 - $urandom_range(0, 60)) : 8'($urandom_range(0, 60));
          end
          2: begin
            // alternating gray gives exact ties
            pb = k[0] ? 8'd128 : 8'd127;
            pg = pb;
            pr = pb;
          end
          default: begin
            pb = tone[23:16];
            pg = tone[15:8];
            pr = tone[7:0];
          end
        endcase
        send_pixel(pb, pg, pr, fs, 1'b0, '0);
        rand_items++;
        quiet = rand_items >= RAND_ITEMS - QUIET_ITEMS;
      end
    end

    settle();
    if (fail_count == 0 && expected_symbols.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cwcc_pkg.sv
hw/rtl/cwcc_classify.sv
hw/rtl/center_window_color_classifier.sv
tb/sv/tb_center_window_color_classifier.sv
